// ===== design/lzsd_pkg.sv =====
// shared constants, codes and control/status types of the lzss stream decompressor
package lzsd_pkg;

   localparam int HISTORY_DEPTH_DEF = 4096;
   localparam int COUNT_WIDTH_DEF   = 24;

   localparam int LEN_WIDTH  = 24;
   localparam int RUN_WIDTH  = 5;
   localparam int FLAG_WIDTH = 9;

   // parse phases
   localparam logic [1:0] PH_FLAG  = 2'd0;
   localparam logic [1:0] PH_ITEM  = 2'd1;
   localparam logic [1:0] PH_TOKHI = 2'd2;

   // what an incoming request turns into
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LIT  = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;

   localparam logic [RUN_WIDTH-1:0] RUN_BIAS = RUN_WIDTH'(3);

   typedef struct packed {
      logic accept;
      logic start_read;
      logic emit;
   } lzsd_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       run_last;
      logic       out_free;
   } lzsd_status_type;

endpackage

// ===== design/lzsd_ctrl.sv =====
// controller state machine of the lzss stream decompressor
module lzsd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lzsd_pkg::lzsd_status_type status,
   output lzsd_pkg::lzsd_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.start_read = 1'b0;
      cmd.emit       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.kind == lzsd_pkg::KIND_LIT) begin
                  state_in = S_EMIT;
               end else if (status.kind == lzsd_pkg::KIND_RUN) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.start_read = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.run_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/lzsd_datapath.sv =====
// parse state, history memory and output register of the lzss stream decompressor
module lzsd_datapath #(
   parameter int HISTORY_DEPTH = lzsd_pkg::HISTORY_DEPTH_DEF,
   parameter int COUNT_WIDTH   = lzsd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_first_of_stream,
   input  logic                          csr_write_enable,
   input  logic [lzsd_pkg::LEN_WIDTH-1:0] csr_write_data,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_run_last,
   output logic                          rsp_stream_end,
   input  lzsd_pkg::lzsd_cmd_type         cmd,
   output lzsd_pkg::lzsd_status_type      status
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int FW = lzsd_pkg::FLAG_WIDTH;
   localparam int RW = lzsd_pkg::RUN_WIDTH;

   logic [7:0] hist_mem [HISTORY_DEPTH];

   logic [lzsd_pkg::LEN_WIDTH-1:0] length_ff;
   logic [FW-1:0]          flag_ff, flag_in;
   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             tok_low_ff, tok_low_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   done_ff, done_in;
   logic                   end_ff, end_in;
   logic                   is_lit_ff, is_lit_in;
   logic [7:0]             lit_byte_ff, lit_byte_in;
   logic [RW-1:0]          run_cnt_ff, run_cnt_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW:0]            fill_ff, fill_in;
   logic [7:0]             rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff;
   logic                   rsp_last_ff;
   logic                   rsp_end_ff;

   logic [FW-1:0]          eff_flag;
   logic [FW-1:0]          flag_shifted;
   logic [1:0]             eff_phase;
   logic [1:0]             phase_after;
   logic [COUNT_WIDTH-1:0] eff_count;
   logic [COUNT_WIDTH-1:0] count_lit;
   logic [COUNT_WIDTH-1:0] count_run;
   logic                   eff_done;
   logic [1:0]             kind;
   logic [RW-1:0]          run_len;
   logic [11:0]            tok_field;
   logic [7:0]             emit_byte;
   logic                   run_last;

   // a new stream restarts parsing before its first byte is consumed
   always_comb begin
      eff_phase = req_first_of_stream ? lzsd_pkg::PH_FLAG : phase_ff;
      eff_flag  = req_first_of_stream ? FW'(1) : flag_ff;
      eff_count = req_first_of_stream ? COUNT_WIDTH'(length_ff) : count_ff;
      eff_done  = req_first_of_stream ? (COUNT_WIDTH'(length_ff) == '0) : done_ff;

      flag_shifted = eff_flag >> 1;
      phase_after  = (flag_shifted <= FW'(1)) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_ITEM;

      run_len   = RW'(req_data_byte[7:4]) + lzsd_pkg::RUN_BIAS;
      tok_field = {req_data_byte[3:0], tok_low_ff};
      count_lit = eff_count - COUNT_WIDTH'(1);
      count_run = (eff_count >= COUNT_WIDTH'(run_len)) ?
                  (eff_count - COUNT_WIDTH'(run_len)) : '0;

      kind = lzsd_pkg::KIND_NONE;
      if (!eff_done) begin
         case (eff_phase)
            lzsd_pkg::PH_ITEM:  kind = eff_flag[0] ? lzsd_pkg::KIND_LIT : lzsd_pkg::KIND_NONE;
            lzsd_pkg::PH_TOKHI: kind = lzsd_pkg::KIND_RUN;
            default:            kind = lzsd_pkg::KIND_NONE;
         endcase
      end
   end

   assign run_last  = is_lit_ff || (run_cnt_ff == RW'(1));
   assign emit_byte = is_lit_ff ? lit_byte_ff : (rd_valid_ff ? rd_data_ff : 8'h00);

   assign status.kind     = kind;
   assign status.run_last = run_last;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      flag_in     = flag_ff;
      phase_in    = phase_ff;
      tok_low_in  = tok_low_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      end_in      = end_ff;
      is_lit_in   = is_lit_ff;
      lit_byte_in = lit_byte_ff;
      run_cnt_in  = run_cnt_ff;
      wp_in       = wp_ff;
      rd_ptr_in   = rd_ptr_ff;
      fill_in     = fill_ff;

      if (cmd.accept) begin
         flag_in  = eff_flag;
         phase_in = eff_phase;
         count_in = eff_count;
         done_in  = eff_done;
         if (!eff_done) begin
            unique case (kind)
               lzsd_pkg::KIND_LIT: begin
                  lit_byte_in = req_data_byte;
                  is_lit_in   = 1'b1;
                  count_in    = count_lit;
                  end_in      = (count_lit == '0);
                  done_in     = (count_lit == '0);
                  flag_in     = flag_shifted;
                  phase_in    = phase_after;
               end
               lzsd_pkg::KIND_RUN: begin
                  is_lit_in  = 1'b0;
                  run_cnt_in = run_len;
                  rd_ptr_in  = wp_ff + AW'(tok_field);
                  count_in   = count_run;
                  end_in     = (count_run == '0);
                  done_in    = (count_run == '0);
                  flag_in    = flag_shifted;
                  phase_in   = phase_after;
               end
               default: begin
                  if (eff_phase == lzsd_pkg::PH_ITEM) begin
                     tok_low_in = req_data_byte;
                     phase_in   = lzsd_pkg::PH_TOKHI;
                  end else begin
                     flag_in  = {1'b1, req_data_byte};
                     phase_in = lzsd_pkg::PH_ITEM;
                  end
               end
            endcase
         end
      end

      if (cmd.emit) begin
         wp_in      = wp_ff + AW'(1);
         rd_ptr_in  = rd_ptr_ff + AW'(1);
         run_cnt_in = run_cnt_ff - RW'(1);
         fill_in    = fill_ff[AW] ? fill_ff : fill_ff + (AW+1)'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         flag_ff      <= FW'(1);
         phase_ff     <= lzsd_pkg::PH_FLAG;
         tok_low_ff   <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b1;
         end_ff       <= 1'b0;
         is_lit_ff    <= 1'b0;
         run_cnt_ff   <= '0;
         wp_ff        <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         flag_ff      <= flag_in;
         phase_ff     <= phase_in;
         tok_low_ff   <= tok_low_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         end_ff       <= end_in;
         is_lit_ff    <= is_lit_in;
         run_cnt_ff   <= run_cnt_in;
         wp_ff        <= wp_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lit_byte_ff <= lit_byte_in;
      if (cmd.emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= run_last;
         rsp_end_ff  <= run_last && end_ff;
      end
   end

   // history memory, entries past the fill count read as zero
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         hist_mem[wp_ff] <= emit_byte;
      end
      if (cmd.start_read) begin
         rd_data_ff  <= hist_mem[rd_ptr_ff];
         rd_valid_ff <= fill_ff[AW] || (rd_ptr_ff < fill_ff[AW-1:0]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_stream_end = rsp_end_ff;

endmodule

// ===== design/lzss_stream_decompressor.sv =====
// LZSS stream decompressor with a 4096-byte history: takes one compressed byte per
// request and delivers the decompressed bytes one per response. Flag bytes, token low
// bytes and ignored bytes are only accepted; a literal is accepted, then emitted; a
// back-reference run of n bytes (3 to 18) alternates a read and an emit per byte, as
// each byte is read from the single history port with a registered read and written
// back before the next read, which keeps overlapping runs exact. A stalled response
// holds the block in its emit state while it waits. History entries never written
// since reset read as zero, tracked by a fill count, so there is no clearing pass
// after reset. Configuration (output length) must be written while the block is
// idle; it is loaded when a request carries first_of_stream.
module lzss_stream_decompressor #(
   parameter int HISTORY_DEPTH = lzsd_pkg::HISTORY_DEPTH_DEF,
   parameter int COUNT_WIDTH   = lzsd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // compressed byte requests
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_first_of_stream,
   // decompressed byte responses
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_run_last,
   output logic                           rsp_stream_end,
   // output length register
   input  logic                           csr_write_enable,
   input  logic [lzsd_pkg::LEN_WIDTH-1:0] csr_write_data
);

   lzsd_pkg::lzsd_cmd_type    cmd;
   lzsd_pkg::lzsd_status_type status;

   // sequencer: accept, then read and emit one history byte at a time
   lzsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // parser state, counters, history memory and response register
   lzsd_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_data_byte       (req_data_byte),
      .req_first_of_stream (req_first_of_stream),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_stream_end      (rsp_stream_end),
      .cmd                 (cmd),
      .status              (status)
   );

`ifndef SYNTH
   // a byte is only emitted into a free response slot
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("emit into occupied response slot");

   // a history read is always followed by an emit attempt, never a new request
   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.start_read |=> (req_stall && !cmd.accept))
      else $error("request accepted during a run");

   // end of stream is only flagged on the last byte of a request
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_stream_end || rsp_run_last))
      else $error("stream end without run last");

   // response valid is raised in the cycle after an emit
   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emit did not raise response valid");
`endif

endmodule

// ===== tb/tb_lzss_stream_decompressor.sv =====
// testbench of the lzss stream decompressor: random compressed streams checked against a predictor
`timescale 1ns / 100ps

module tb_lzss_stream_decompressor;

   localparam int HIST_SIZE     = lzsd_pkg::HISTORY_DEPTH_DEF;
   localparam int CW            = lzsd_pkg::COUNT_WIDTH_DEF;
   localparam int LW            = lzsd_pkg::LEN_WIDTH;
   localparam int FLW           = lzsd_pkg::FLAG_WIDTH;
   localparam int SETTLE_CYCLES = 48;      // margin for the longest run of 18 bytes
   localparam int REGIME_ITEMS  = 56;      // counted requests per idling regime

   // one decompressed byte as the block should deliver it
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       ends;
   } out_rec_type;

   // one compressed byte with its stream start mark
   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } req_item_type;

   // predictor of the decompressed bytes plus the queue of bytes still owed by the block
   class decomp_tracker_type;
      logic [7:0]    history_mem [HIST_SIZE];
      logic [11:0]   wr_ptr;
      logic [FLW-1:0] flag_bits;
      logic [1:0]    phase;
      logic [7:0]    tok_lo;
      logic [CW-1:0] bytes_left;
      logic          done;
      logic [LW-1:0] length_reg;
      out_rec_type   expected_q [$];
      int            fail_count;

      function new();
         foreach (history_mem[i]) history_mem[i] = 8'h00;
         wr_ptr     = '0;
         flag_bits  = 9'd1;
         phase      = lzsd_pkg::PH_FLAG;
         tok_lo     = '0;
         bytes_left = '0;
         done       = 1'b1;
         length_reg = '0;
         fail_count = 0;
      endfunction

      function void set_length(logic [LW-1:0] len);
         length_reg = len;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_byte(logic [7:0] v);
         out_rec_type rec;
         rec.data = v;
         rec.last = 1'b0;
         rec.ends = 1'b0;
         expected_q.push_back(rec);
         history_mem[wr_ptr] = v;
         wr_ptr = wr_ptr + 12'd1;
      endfunction

      // end of a literal or a run: advance flags, mark the last byte
      function void close_item();
         flag_bits = flag_bits >> 1;
         phase = (flag_bits <= 9'd1) ? lzsd_pkg::PH_FLAG : lzsd_pkg::PH_ITEM;
         expected_q[expected_q.size()-1].last = 1'b1;
         if (bytes_left == '0) begin
            done = 1'b1;
            expected_q[expected_q.size()-1].ends = 1'b1;
         end
      endfunction

      function void note_request(logic [7:0] b, logic first);
         logic [15:0] tok;
         logic [12:0] back_dist;
         logic [11:0] rd;
         int          run;
         if (first) begin
            bytes_left = CW'(length_reg);
            done       = (length_reg == '0);
            phase      = lzsd_pkg::PH_FLAG;
            flag_bits  = 9'd1;
         end
         if (done) return;
         if (phase == lzsd_pkg::PH_ITEM) begin
            if (flag_bits[0]) begin
               push_byte(b);
               bytes_left = bytes_left - 1'b1;
               close_item();
            end else begin
               tok_lo = b;
               phase  = lzsd_pkg::PH_TOKHI;
            end
         end else if (phase == lzsd_pkg::PH_TOKHI) begin
            tok       = {b, tok_lo};
            back_dist = 13'h1000 - {1'b0, tok[11:0]};
            run       = int'(tok[15:12]) + 3;
            bytes_left = (bytes_left >= CW'(run)) ? bytes_left - CW'(run) : '0;
            for (int k = 0; k < run; k++) begin
               rd = wr_ptr - back_dist[11:0];
               push_byte(history_mem[rd]);
            end
            close_item();
         end else begin
            flag_bits = {1'b1, b};
            phase     = lzsd_pkg::PH_ITEM;
         end
      endfunction

      function void check_response(logic [7:0] d, logic l, logic e);
         out_rec_type want;
         out_rec_type got;
         got.data = d;
         got.last = l;
         got.ends = e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual byte %h last %b end %b",
                     $time, d, l, e);
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         if (want != got) begin
            $display("%0t: mismatch, expected byte %h last %b end %b, actual byte %h last %b end %b",
                     $time, want.data, want.last, want.ends, got.data, got.last, got.ends);
            fail_count++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [7:0]    req_data_byte;
   logic          req_first_of_stream;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [7:0]    rsp_out_byte;
   logic          rsp_run_last;
   logic          rsp_stream_end;
   logic          csr_write_enable;
   logic [LW-1:0] csr_write_data;

   decomp_tracker_type tracker;
   int                 sender_idle_pct;
   int                 receiver_idle_pct;
   req_item_type       stream_q [$];

   lzss_stream_decompressor dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_first_of_stream (req_first_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_stream_end      (rsp_stream_end),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs or drops bytes
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // response side: check accepted bytes, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_response(rsp_out_byte, rsp_run_last, rsp_stream_end);
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // one request: random idle gap, then hold valid until the block takes it
   task automatic send_request(input logic [7:0] d, input logic f);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data_byte       <= d;
      req_first_of_stream <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(d, f);
   endtask

   // length register write, only once the block has drained
   task automatic write_length(input logic [LW-1:0] len);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      // flag or token low bytes give no response, so leave room for one in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_length(len);
   endtask

   // well-formed compressed stream that decodes to at least produce bytes
   function automatic void build_stream(int produce);
      logic [7:0]  flags;
      logic [11:0] field;
      logic [3:0]  runf;
      logic        first_mark;
      int          made;
      int          distance;
      int          sel;
      stream_q.delete();
      made       = 0;
      first_mark = 1'b1;
      while (made < produce) begin
         flags = 8'($urandom_range(255));
         stream_q.push_back('{data: flags, first: first_mark});
         first_mark = 1'b0;
         for (int i = 0; i < 8 && made < produce; i++) begin
            if (flags[i]) begin
               stream_q.push_back('{data: 8'($urandom_range(255)), first: 1'b0});
               made++;
            end else begin
               // mostly short distances so runs overlap themselves
               sel = $urandom_range(9);
               if (sel < 6)
                  distance = $urandom_range(1, 24);
               else if (sel < 8)
                  distance = $urandom_range(1, 4096);
               else if (sel == 8)
                  distance = 1;
               else
                  distance = 4096;
               field = 12'(4096 - distance);
               runf  = 4'($urandom_range(15));
               stream_q.push_back('{data: field[7:0], first: 1'b0});
               stream_q.push_back('{data: {runf, field[11:8]}, first: 1'b0});
               made += int'(runf) + 3;
            end
         end
      end
   endfunction

   // one idling regime of random streams, broken streams and noise
   task automatic run_regime(input int s_pct, input int r_pct);
      logic [LW-1:0] len;
      int sent;
      int pick;
      int produce;
      int keep;
      sender_idle_pct   = s_pct;
      receiver_idle_pct = r_pct;
      sent = 0;
      while (sent < REGIME_ITEMS) begin
         pick = $urandom_range(19);
         case (pick)
            0:       len = '0;
            1:       len = '1;
            2:       len = 24'd1;
            3:       len = LW'($urandom);
            default: len = LW'($urandom_range(2, 40));
         endcase
         write_length(len);
         if (len == '0)
            produce = 4;
         else if (len > 40)
            produce = $urandom_range(10, 40);
         else
            produce = int'(len);
         build_stream(produce);
         pick = $urandom_range(99);
         if (pick < 8) begin
            // noise: random bytes, stream starts sprinkled in
            stream_q.delete();
            repeat ($urandom_range(3, 10))
               stream_q.push_back('{data: 8'($urandom_range(255)),
                                    first: ($urandom_range(7) == 0)});
         end else if (pick < 20) begin
            // broken stream: cut anywhere, the next start has to recover
            keep = $urandom_range(1, stream_q.size());
            while (stream_q.size() > keep) void'(stream_q.pop_back());
         end else if (pick < 40) begin
            // trailing bytes past the end of the stream
            repeat ($urandom_range(1, 3))
               stream_q.push_back('{data: 8'($urandom_range(255)), first: 1'b0});
         end
         foreach (stream_q[i])
            send_request(stream_q[i].data, stream_q[i].first);
         if (len != '0) sent += stream_q.size();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_data_byte       = 8'h00;
      req_first_of_stream = 1'b0;
      rsp_stall           = 1'b0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      tracker             = new();
      sender_idle_pct     = 20;
      receiver_idle_pct   = 81;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle after reset: byte is ignored
      send_request(8'hA5, 1'b0);

      // zero length: start byte ignored, so is the next
      write_length(24'd0);
      send_request(8'hFF, 1'b1);
      send_request(8'h00, 1'b0);

      // literals 00/ff, distance 1 run 18, distance 4096 run 3, then a run past the count
      write_length(24'd30);
      send_request(8'h53, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'h5A, 1'b0);
      send_request(8'hFE, 1'b0);
      send_request(8'hFF, 1'b0);
      // stream has ended, these are dropped
      send_request(8'h12, 1'b0);
      send_request(8'h34, 1'b0);

      // full group of literals, second flag byte, run ends exactly on the count
      write_length(24'd11);
      send_request(8'hFF, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'hFE, 1'b0);
      send_request(8'h55, 1'b0);
      send_request(8'hAA, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFD, 1'b0);
      send_request(8'h0F, 1'b0);

      // largest length: stream keeps going
      write_length(24'hFFFFFF);
      send_request(8'h01, 1'b1);
      send_request(8'h42, 1'b0);

      // random streams under the three idling regimes
      run_regime(20, 81);
      run_regime(81, 20);
      run_regime(0, 0);

      // drain, then allow for any byte still in the block
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lzsd_pkg.sv
design/lzsd_ctrl.sv
design/lzsd_datapath.sv
design/lzss_stream_decompressor.sv
tb/tb_lzss_stream_decompressor.sv
